// ===== rtl/wwr_pkg.sv =====
// ============================================================================
// Whole-word replace package
// Shared types, register indexes and helper functions of the replace stream.
// ============================================================================
`default_nettype none

package wwr_pkg;

    // Widest supported word and the fixed byte width of a character.
    localparam int WORD_BYTES = 8;
    localparam int CHAR_W     = 8;
    // Most characters that one input transfer can cause.
    localparam logic [4:0] OUT_CAP = 5'd9;

    // Configuration register indexes.
    localparam logic [1:0] REG_FIND_WORD      = 2'd0;
    localparam logic [1:0] REG_FIND_LENGTH    = 2'd1;
    localparam logic [1:0] REG_REPLACE_WORD   = 2'd2;
    localparam logic [1:0] REG_REPLACE_LENGTH = 2'd3;

    typedef struct packed {
        logic [63:0] find_word;
        logic [3:0]  find_length;
        logic [63:0] replace_word;
        logic [3:0]  replace_length;
    } cfg_t;

    // What the leading run of a command carries.
    typedef enum logic [1:0] {
        SEG_NONE,
        SEG_HELD,
        SEG_REPL
    } seg_t;

    // One command from the classifier to the emitter. Its output is the
    // leading run, then the current character, then a trailing replacement.
    typedef struct packed {
        logic [63:0] held_chars;
        logic [3:0]  held_n;
        seg_t        seg1;
        logic        emit_c;
        logic [7:0]  ch;
        logic        seg2_repl;
        logic        last;
    } cmd_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic [7:0] word_byte(input logic [63:0] w, input logic [2:0] i);
        return w[{i, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/wwr_fifo.sv =====
// ============================================================================
// Command queue
// Small register queue that decouples the classifier from the emitter.
// ============================================================================
`default_nettype none

module wwr_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire wwr_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output wwr_pkg::cmd_t      head_cmd
);
    import wwr_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg,  count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == (PW+1)'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wwr_front.sv =====
// ============================================================================
// Classifier
// Tracks the partial match and turns each character into at most one command.
// ============================================================================
`default_nettype none

module wwr_front #(
    parameter int MAX_WORD = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire wwr_pkg::cfg_t cfg,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,
    input  wire logic          s_tlast,
    output logic               push,
    output wwr_pkg::cmd_t      push_cmd,
    input  wire logic          fifo_full
);
    import wwr_pkg::*;

    localparam logic [3:0] CAP = 4'(MAX_WORD);

    logic [7:0] held_reg [MAX_WORD];
    logic [3:0] held_count_reg, held_count_next;
    logic       prev_letter_reg, prev_letter_next;
    logic       held_letter_reg, held_letter_next;

    logic        accept;
    logic [3:0]  len, r_len, r_m1;
    logic        repl_letter, c_letter, p_base;
    logic        extend, do_start, hold_start;
    logic [63:0] snap;
    cmd_t        cmd;

    assign s_tready = !fifo_full;
    assign accept   = s_tvalid && s_tready;
    assign c_letter = is_letter(s_tdata);

    always_comb begin
        if (cfg.find_length == 4'd0) begin
            len = 4'd1;
        end else if (cfg.find_length > CAP) begin
            len = CAP;
        end else begin
            len = cfg.find_length;
        end
        r_len       = (cfg.replace_length > CAP) ? CAP : cfg.replace_length;
        r_m1        = r_len - 4'd1;
        repl_letter = is_letter(word_byte(cfg.replace_word, r_m1[2:0]));
    end

    // Held characters with the current one placed at the next free slot.
    always_comb begin
        snap = '0;
        for (int i = 0; i < MAX_WORD; i++) begin
            snap[CHAR_W*i +: CHAR_W] = (held_count_reg == 4'(i)) ? s_tdata : held_reg[i];
        end
    end

    always_comb begin
        cmd              = '0;
        cmd.held_chars   = snap;
        cmd.held_n       = held_count_reg;
        cmd.seg1         = SEG_NONE;
        cmd.ch           = s_tdata;
        cmd.last         = s_tlast;
        extend           = 1'b0;
        do_start         = 1'b0;
        hold_start       = 1'b0;
        p_base           = prev_letter_reg;
        held_count_next  = held_count_reg;
        prev_letter_next = prev_letter_reg;
        held_letter_next = held_letter_reg;

        if (held_count_reg >= len) begin
            if (c_letter) begin
                cmd.seg1 = SEG_HELD;
                p_base   = held_letter_reg;
            end else begin
                cmd.seg1 = SEG_REPL;
                p_base   = (r_len != 4'd0) ? repl_letter : prev_letter_reg;
            end
            do_start = 1'b1;
        end else if (held_count_reg != 4'd0) begin
            if (s_tdata == word_byte(cfg.find_word, held_count_reg[2:0])) begin
                extend           = 1'b1;
                held_count_next  = held_count_reg + 4'd1;
                held_letter_next = c_letter;
            end else begin
                cmd.seg1 = SEG_HELD;
                p_base   = held_letter_reg;
                do_start = 1'b1;
            end
        end else begin
            do_start = 1'b1;
        end

        if (do_start) begin
            if (!p_base && (s_tdata == cfg.find_word[7:0])) begin
                hold_start       = 1'b1;
                held_count_next  = 4'd1;
                held_letter_next = c_letter;
                prev_letter_next = p_base;
            end else begin
                cmd.emit_c       = 1'b1;
                held_count_next  = 4'd0;
                prev_letter_next = c_letter;
            end
        end

        // End of text flushes whatever is still held.
        if (s_tlast) begin
            if (hold_start) begin
                if (len == 4'd1) begin
                    cmd.seg2_repl = 1'b1;
                end else begin
                    cmd.emit_c = 1'b1;
                end
            end else if (extend) begin
                cmd.held_n = held_count_next;
                cmd.seg1   = (held_count_next >= len) ? SEG_REPL : SEG_HELD;
            end
            held_count_next  = 4'd0;
            prev_letter_next = 1'b0;
        end
    end

    assign push     = accept && ((cmd.seg1 != SEG_NONE) || cmd.emit_c || cmd.seg2_repl);
    assign push_cmd = cmd;

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < MAX_WORD; i++) begin
                if ((extend && (held_count_reg == 4'(i))) || (hold_start && (i == 0))) begin
                    held_reg[i] <= s_tdata;
                end
            end
            held_letter_reg <= held_letter_next;
        end
        if (!aresetn) begin
            held_count_reg  <= '0;
            prev_letter_reg <= 1'b0;
        end else if (accept) begin
            held_count_reg  <= held_count_next;
            prev_letter_reg <= prev_letter_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wwr_back.sv =====
// ============================================================================
// Emitter
// Expands each command into output characters, one per cycle unless stalled.
// ============================================================================
`default_nettype none

module wwr_back #(
    parameter int MAX_WORD = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire wwr_pkg::cfg_t cfg,
    input  wire logic          head_valid,
    input  wire wwr_pkg::cmd_t head_cmd,
    output logic               pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast
);
    import wwr_pkg::*;

    localparam logic [3:0] CAP = 4'(MAX_WORD);

    logic [3:0] k_reg, k_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;

    logic [3:0] r_len, len1, j;
    logic [4:0] sum, total;
    logic       advance, final_char;
    logic [7:0] ch_sel;

    assign r_len   = (cfg.replace_length > CAP) ? CAP : cfg.replace_length;
    assign advance = head_valid && (!m_tvalid_reg || m_tready);

    always_comb begin
        case (head_cmd.seg1)
            SEG_HELD: len1 = head_cmd.held_n;
            SEG_REPL: len1 = r_len;
            default:  len1 = 4'd0;
        endcase
        sum = 5'(len1) + 5'(head_cmd.emit_c) + (head_cmd.seg2_repl ? 5'(r_len) : 5'd0);
        total      = (sum > OUT_CAP) ? OUT_CAP : sum;
        final_char = (5'(k_reg) + 5'd1 >= total);
        j          = k_reg - len1 - 4'(head_cmd.emit_c);

        if (k_reg < len1) begin
            ch_sel = (head_cmd.seg1 == SEG_HELD) ? word_byte(head_cmd.held_chars, k_reg[2:0])
                                                 : word_byte(cfg.replace_word, k_reg[2:0]);
        end else if (head_cmd.emit_c && (k_reg == len1)) begin
            ch_sel = head_cmd.ch;
        end else begin
            ch_sel = word_byte(cfg.replace_word, j[2:0]);
        end
    end

    always_comb begin
        pop           = advance && final_char;
        k_next        = k_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (advance) begin
            k_next        = final_char ? 4'd0 : k_reg + 4'd1;
            m_tvalid_next = (total != 5'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= ch_sel;
            m_tlast_reg <= head_cmd.last && final_char;
        end
        if (!aresetn) begin
            k_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            k_reg        <= k_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

// ===== rtl/whole_word_replace_stream.sv =====
// ============================================================================
// Whole-word replace stream
// Replaces every whole-word occurrence of a find word in a byte stream.
// ============================================================================
//
//  Channel   Direction  Transfer when          Payload
//  s_*       in         s_tvalid & s_tready    s_tdata = in_char, s_tlast = in_last
//  m_*       out        m_tvalid & m_tready    m_tdata = out_char, m_tlast = out_last
//  cfg_*     in         cfg_we                 cfg_index selects, cfg_wdata is the value
//
// The classifier accepts a new transfer every cycle while the command queue
// has room. The emitter produces one output character per cycle while the
// output is not stalled, so a character that releases a held partial match
// or a replacement word can cause up to nine output characters; the output
// rate of the emitter sets the sustained throughput.
// Reset is synchronous and active low; it empties the queue, clears the match
// state and drops m_tvalid. Either side may stall without losing data: the
// four-entry queue and the output register absorb backpressure.
//
`default_nettype none

module whole_word_replace_stream #(
    parameter int MAX_WORD = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port.
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_char
    input  wire logic        s_tlast,   // in_last
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_char
    output logic             m_tlast    // out_last
);
    import wwr_pkg::*;

    // Configuration registers. The user must have writes arrive only while the
    // block is idle; the block does not enforce it. Both halves read them directly.
    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{find_word: '0, find_length: 4'd1,
                         replace_word: '0, replace_length: '0};
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FIND_WORD:      cfg_reg.find_word      <= cfg_wdata;
                REG_FIND_LENGTH:    cfg_reg.find_length    <= cfg_wdata[3:0];
                REG_REPLACE_WORD:   cfg_reg.replace_word   <= cfg_wdata;
                REG_REPLACE_LENGTH: cfg_reg.replace_length <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // The classifier turns each transfer into at most one command; the
    // emitter drains commands at one output character per cycle unless stalled.
    logic fifo_full, push, pop, head_valid;
    cmd_t push_cmd, head_cmd;

    wwr_front #(
        .MAX_WORD (MAX_WORD)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .push      (push),
        .push_cmd  (push_cmd),
        .fifo_full (fifo_full)
    );

    wwr_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    wwr_back #(
        .MAX_WORD (MAX_WORD)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/wwr_checker.sv =====
// ============================================================================
// Port checker
// Concurrent checks on the ports of the replace stream, bound to the top.
// ============================================================================
`default_nettype none

module wwr_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    // Reset leaves the output empty and the input open.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("output valid or input blocked after reset");

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("result changed while stalled");

    // Right after reset, nothing comes out unless a character went in.
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(!aresetn) && !(s_tvalid && s_tready)) |=> !m_tvalid)
        else $error("result appeared without input");

endmodule

bind whole_word_replace_stream wwr_checker u_wwr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== sim/tb_whole_word_replace_stream.sv =====
// ============================================================================
// Whole-word replace stream testbench
// Streams text through the replacer under several find and replacement word
// settings. Each output character is checked against a typed script row or
// a cycle-free whole-word rewrite model in step with each accepted transfer.
// ============================================================================
`default_nettype none

module tb_whole_word_replace_stream;
    timeunit 1ns;
    timeprecision 1ps;

    import wwr_pkg::*;

    // After the last expected character has come out, characters that are
    // only held back may still sit in the command queue; this many cycles
    // cover the classifier and the four-entry queue with margin.
    localparam int DRAIN_CYCLES = 20;
    // This limit leaves ample room above the slowest correct run.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_ITEMS  = 35;

    // One character of the rewritten text as the result channel carries it.
    typedef struct packed {
        logic [7:0] ch;
        logic       lst;
    } text_char_t;

    // A directed script row is either a register write or one character.
    typedef enum logic {
        ROW_CFG,
        ROW_CHR
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [1:0] idx;
        logic [63:0] data;
        logic [7:0] ch;
        logic       lst;
        logic       typed;     // The single expected character is spelled out.
        logic [7:0] want_ch;
        logic       want_lst;
    } row_t;

    localparam int DIR_N = 31;

    // Directed script. The first rows run on the reset settings, where the
    // find word is a single zero byte and the replacement is empty, so a
    // lone zero byte between non-letters is deleted. Then a three-letter
    // word is exercised against a space, a trailing letter, a mismatch and
    // the end of text. Last, a zero find length and an oversized replacement
    // length drive a single-byte match on both final characters, which
    // overflows the nine results a transfer may cause.
    localparam row_t SCRIPT [DIR_N] = '{
        '{ROW_CHR, REG_FIND_WORD, 64'd0, "a",   1'b0, 1'b1, "a",   1'b0},
        '{ROW_CHR, REG_FIND_WORD, 64'd0, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0},
        '{ROW_CHR, REG_FIND_WORD, 64'd0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CHR, REG_FIND_WORD, 64'd0, " ",   1'b0, 1'b1, " ",   1'b0},
        '{ROW_CHR, REG_FIND_WORD, 64'd0, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1},
        '{ROW_CFG, REG_FIND_WORD,      64'hA5A5_A5A5_A574_6163, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG, REG_FIND_LENGTH,    64'd3,                   8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG, REG_REPLACE_WORD,   64'h5A5A_5A5A_5A5A_5A78, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG, REG_REPLACE_LENGTH, 64'd1,                   8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CHR, REG_FIND_WORD, 64'd0, "c", 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CHR, REG_FIND_WORD, 64'd0, "a", 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CHR, REG_FIND_WORD, 64'd0, "t", 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CHR, REG_FIND_WORD, 64'd0, " ", 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CHR, REG_FIND_WORD, 64'd0, "c", 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CHR, REG_FIND_WORD, 64'd0, "a", 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CHR, REG_FIND_WORD, 64'd0, "t", 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CHR, REG_FIND_WORD, 64'd0, "s", 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CHR, REG_FIND_WORD, 64'd0, " ", 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CHR, REG_FIND_WORD, 64'd0, "c", 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CHR, REG_FIND_WORD, 64'd0, "a", 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CHR, REG_FIND_WORD, 64'd0, "r", 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CHR, REG_FIND_WORD, 64'd0, " ", 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CHR, REG_FIND_WORD, 64'd0, "c", 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CHR, REG_FIND_WORD, 64'd0, "a", 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CHR, REG_FIND_WORD, 64'd0, "t", 1'b1, 1'b1, "x",   1'b1},
        '{ROW_CFG, REG_FIND_WORD,      64'hFFFF_FFFF_FFFF_FF2D, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG, REG_FIND_LENGTH,    64'd0,                   8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG, REG_REPLACE_WORD,   64'hFF80_7A5A_6141_2000, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CFG, REG_REPLACE_LENGTH, 64'd15,                  8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CHR, REG_FIND_WORD, 64'd0, "-", 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_CHR, REG_FIND_WORD, 64'd0, "-", 1'b1, 1'b0, 8'h00, 1'b0}
    };

    // Clock, reset and the ports of the block. Every input starts known.
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = REG_FIND_WORD;
    logic [63:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] in_char
    logic        s_tlast   = 1'b0; // in_last
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] out_char
    logic        m_tlast;          // out_last

    // Settings as the block should hold them, and the match state.
    logic [63:0] cf_find  = '0;
    logic [3:0]  cf_flen  = 4'd1;
    logic [63:0] cf_repl  = '0;
    logic [3:0]  cf_rlen  = 4'd0;
    logic [7:0]  held_buf [8];
    int          held_n      = 0;
    logic        prev_letter = 1'b0;

    // Characters caused by the transfer just accepted, and the rewritten
    // text still owed by the block, oldest first.
    text_char_t  step_out[$];
    text_char_t  owed_text[$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  stall_pct      = 0;   // Chance that m_tready drops for a burst.
    int  gap_pct        = 0;   // Chance of a gap after an input transfer.
    bit  tx_high        = 1'b0;
    bit  cfg_high       = 1'b0;

    whole_word_replace_stream u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Rewrite model
    // ------------------------------------------------------------------

    function automatic logic alpha(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    // A zero find length acts as one; lengths past eight act as eight.
    function automatic int find_span();
        if (cf_flen == 4'd0) return 1;
        return (cf_flen > 4'd8) ? 8 : int'(cf_flen);
    endfunction

    // Anything past nine characters in one step is lost.
    function automatic void emit_char(input logic [7:0] c);
        if (step_out.size() < int'(OUT_CAP)) step_out.push_back('{ch: c, lst: 1'b0});
    endfunction

    function automatic void release_held();
        for (int i = 0; i < held_n; i++) emit_char(held_buf[i]);
        if (held_n > 0) prev_letter = alpha(held_buf[held_n - 1]);
        held_n = 0;
    endfunction

    function automatic void emit_replacement();
        int r;
        r = (cf_rlen > 4'd8) ? 8 : int'(cf_rlen);
        for (int i = 0; i < r; i++) emit_char(cf_repl[8*i +: 8]);
        if (r > 0) prev_letter = alpha(cf_repl[8*(r-1) +: 8]);
        held_n = 0;
    endfunction

    // A match may only open right after a non-letter in the output.
    function automatic void try_open(input logic [7:0] c);
        if (!prev_letter && (c == cf_find[7:0])) begin
            held_buf[0] = c;
            held_n = 1;
        end else begin
            emit_char(c);
            prev_letter = alpha(c);
        end
    endfunction

    // Fills step_out with the characters one input transfer causes.
    function automatic void rewrite_char(input logic [7:0] c, input logic l);
        int flen;
        flen = find_span();
        step_out.delete();
        if (held_n >= flen) begin
            // A complete word stands only if a non-letter follows it.
            if (alpha(c)) release_held();
            else emit_replacement();
            try_open(c);
        end else if (held_n > 0) begin
            if (c == cf_find[8*held_n +: 8]) begin
                held_buf[held_n] = c;
                held_n++;
            end else begin
                release_held();
                try_open(c);
            end
        end else begin
            try_open(c);
        end
        if (l) begin
            if (held_n > 0) begin
                if (held_n >= flen) emit_replacement();
                else release_held();
            end
            // When the final character causes nothing, no output is marked.
            if (step_out.size() > 0) step_out[step_out.size() - 1].lst = 1'b1;
            held_n = 0;
            prev_letter = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    task automatic lower_inputs();
        if (tx_high) begin
            s_tvalid <= 1'b0;
            tx_high = 1'b0;
        end
        if (cfg_high) begin
            cfg_we <= 1'b0;
            cfg_high = 1'b0;
        end
    endtask

    // One register write; the model takes the value at the same edge.
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        cfg_high = 1'b1;
        @(posedge aclk);
        case (idx)
            REG_FIND_WORD:      cf_find = data;
            REG_FIND_LENGTH:    cf_flen = data[3:0];
            REG_REPLACE_WORD:   cf_repl = data;
            REG_REPLACE_LENGTH: cf_rlen = data[3:0];
            default: ;
        endcase
    endtask

    // Holds the input back until the block owes nothing, then lets the
    // characters that cause no output clear the pipeline as well.
    task automatic wait_drained();
        lower_inputs();
        while (owed_text.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Offers one character and waits for its transfer. A typed row supplies
    // its own expected character in place of the model's output.
    task automatic send_char(input logic [7:0] c, input logic l,
                             input logic typed, input text_char_t want);
        if (cfg_high) begin
            cfg_we <= 1'b0;
            cfg_high = 1'b0;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= l;
        tx_high = 1'b1;
        do @(posedge aclk); while (!s_tready);
        rewrite_char(c, l);
        if (typed) owed_text.push_back(want);
        else foreach (step_out[i]) owed_text.push_back(step_out[i]);
        if ($urandom_range(0, 99) < gap_pct) begin
            lower_inputs();
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    // Mostly letters that fall into words built from the find word.
    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 5))
            0: return "a";
            1: return "b";
            2: return "A";
            3: return "B";
            default: return 8'(("a" + $urandom_range(0, 25)));
        endcase
    endfunction

    // Non-letters, with the neighbors of both letter ranges favored.
    function automatic logic [7:0] pick_gap_char();
        case ($urandom_range(0, 7))
            0: return " ";
            1: return ".";
            2: return 8'h40;
            3: return 8'h5B;
            4: return 8'h60;
            5: return 8'h7B;
            6: return 8'h00;
            default: return 8'h80 | 8'($urandom_range(0, 127));
        endcase
    endfunction

    task automatic send_text(input logic [7:0] c);
        send_char(c, ($urandom_range(0, 19) == 0), 1'b0, '0);
    endtask

    // Writes all four registers. The first phases pin the extremes of the
    // lengths; the rest pick freely, now and then past the word size.
    task automatic setup_phase(input int phase);
        logic [63:0] word;
        int          flen;
        int          rlen;
        for (int i = 0; i < 8; i++)
            word[8*i +: 8] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : pick_letter();
        case (phase)
            0: begin flen = 8;  rlen = 8;  end
            1: begin flen = 1;  rlen = 0;  end
            2: begin flen = 15; rlen = 15; end
            3: begin flen = 0;  rlen = 1;  end
            default: begin
                flen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
                rlen = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
            end
        endcase
        write_reg(REG_FIND_WORD, word);
        write_reg(REG_FIND_LENGTH, 64'(flen));
        if ($urandom_range(0, 1) == 0) begin
            for (int i = 0; i < 8; i++)
                word[8*i +: 8] = ($urandom_range(0, 1) == 0) ? pick_letter() : pick_gap_char();
        end else begin
            word = {$urandom, $urandom};
        end
        write_reg(REG_REPLACE_WORD, word);
        write_reg(REG_REPLACE_LENGTH, 64'(rlen));
    endtask

    // Random text made mostly of whole and partial copies of the find word
    // between separators, with stray letters and raw bytes as noise.
    task automatic run_phase(input int n_items);
        int sent;
        int span;
        int pick;
        sent = 0;
        while (sent < n_items) begin
            span = find_span();
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                for (int i = 0; i < span; i++) send_text(cf_find[8*i +: 8]);
                sent += span;
            end else if (pick < 55) begin
                span = (span > 1) ? $urandom_range(1, span - 1) : 1;
                for (int i = 0; i < span; i++) send_text(cf_find[8*i +: 8]);
                sent += span;
            end else if (pick < 70) begin
                send_text(pick_letter());
                sent++;
            end else if (pick < 90) begin
                send_text(pick_gap_char());
                sent++;
            end else begin
                send_text(8'($urandom));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // The receiver stalls in random bursts.
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 99) < stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Each output transfer is compared with the oldest owed character.
    always @(posedge aclk) begin : check_output
        text_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (owed_text.size() == 0) begin
                $display("%0t: unexpected output, expected nothing, actual char %02h last %0b",
                         $time, m_tdata, m_tlast);
                mismatch_count++;
            end else begin
                want = owed_text.pop_front();
                if (m_tdata !== want.ch) begin
                    $display("%0t: out_char mismatch, expected %02h, actual %02h",
                             $time, want.ch, m_tdata);
                    mismatch_count++;
                end
                if (m_tlast !== want.lst) begin
                    $display("%0t: out_last mismatch, expected %0b, actual %0b",
                             $time, want.lst, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The directed script runs first with light idling on both sides.
        gap_pct   = 20;
        stall_pct = 20;
        for (int i = 0; i < DIR_N; i++) begin
            if (SCRIPT[i].kind == ROW_CFG) begin
                // Registers change only once the previous text has drained.
                if (!cfg_high) wait_drained();
                write_reg(SCRIPT[i].idx, SCRIPT[i].data);
            end else begin
                send_char(SCRIPT[i].ch, SCRIPT[i].lst, SCRIPT[i].typed,
                          '{ch: SCRIPT[i].want_ch, lst: SCRIPT[i].want_lst});
            end
        end

        // Random phases. A phase often ends in the middle of a text, so the
        // next settings meet held characters. Some phases run with no idling
        // at all, and the last two keep both sides busy throughout.
        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_drained();
            if ((p % 4 == 1) || (p >= RAND_PHASES - 2)) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = $urandom_range(10, 40);
                stall_pct = $urandom_range(10, 50);
            end
            setup_phase(p);
            run_phase(PHASE_ITEMS);
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== whole_word_replace_stream.f =====
rtl/wwr_pkg.sv
rtl/wwr_fifo.sv
rtl/wwr_front.sv
rtl/wwr_back.sv
rtl/whole_word_replace_stream.sv
rtl/wwr_checker.sv
sim/tb_whole_word_replace_stream.sv
